// ===== rtl/core/mep_pkg.sv =====
// Shared definitions for the midpoint ellipse point generator.
// Register indexes and the control struct between sequencer and top level.
// No dependencies.
`default_nettype none

package mep_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_ADDR_W     = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS_X = 2'd2,
        CFG_RADIUS_Y = 2'd3
    } cfg_idx_t;

    // Sequencer status towards the output stage
    typedef struct packed {
        logic idle;   // ready for the next input transaction
        logic done;   // result loads into the output register this cycle
        logic blank;  // no ellipse active: result is all zeros
    } seq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mep_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Used by mep_core for every product of a point step; depends on mep_pkg.
`default_nettype none

module mep_mul #(
    parameter int A_W = 2 * (mep_pkg::COORD_BITS_DEF - 1),
    parameter int B_W = mep_pkg::COORD_BITS_DEF + 1
) (
    input  logic                 clk,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   prod
);
    import mep_pkg::*;

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0] prod_reg;
    logic [P_W-1:0] prod_next;

    assign prod_next = P_W'(a) * P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mep_core.sv =====
// Sequencer and decision datapath of the midpoint ellipse point generator.
// Drives the shared multiplier mep_mul; uses mep_pkg for the control struct.
`default_nettype none

module mep_core #(
    parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    restart,
    input  logic [COORD_BITS-2:0]   radius_x,
    input  logic [COORD_BITS-2:0]   radius_y,
    input  logic                    out_free,
    output mep_pkg::seq_ctl_t       ctl,
    output logic [COORD_BITS-1:0]   offset_x,
    output logic [COORD_BITS:0]     offset_y
);
    import mep_pkg::*;

    localparam int RAD  = COORD_BITS - 1;
    localparam int OFFY = COORD_BITS + 1;
    localparam int STEP = 3 * COORD_BITS;
    localparam int DEC  = 3 * COORD_BITS + 6;
    localparam int MA   = 2 * RAD;
    localparam int MB   = COORD_BITS + 1;
    localparam int PW   = MA + MB;
    localparam int SW   = 2 * COORD_BITS + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_RX, S_RY,
        S_R2, S_R3,
        S_A2, S_A3, S_A4,
        S_B2, S_B3, S_B4,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        M_RESTART,
        M_REGION1,
        M_REGION2
    } mode_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic                   in_r2_reg, in_r2_next;
    logic                   finished_reg, finished_next;
    logic                   blank_reg, blank_next;
    logic                   flag_reg, flag_next;
    logic [COORD_BITS-1:0]  x_reg, x_next;
    logic [OFFY-1:0]        y_reg, y_next;

    logic [MA-1:0]          rx2_reg, rx2_next;
    logic [MA-1:0]          ry2_reg, ry2_next;
    logic [DEC-1:0]         dec_reg, dec_next;
    logic [SW-1:0]          s_reg, s_next;
    logic [STEP-1:0]        dx_reg, dx_next;

    logic [MA-1:0]          mul_a;
    logic [MB-1:0]          mul_b;
    logic [PW-1:0]          prod;

    logic [STEP-1:0]        step_term;
    logic                   dec_neg;
    logic                   dec_zero;
    logic [OFFY-1:0]        ym1;
    logic [COORD_BITS:0]    x_inc;

    mep_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // 2 * product, wrapped to the step width
    assign step_term = STEP'({prod, 1'b0});
    assign dec_neg   = dec_reg[DEC-1];
    assign dec_zero  = (dec_reg == '0);
    // (y-1)^2 with y = 0 counts as 1
    assign ym1       = (y_reg != '0) ? (y_reg - OFFY'(1)) : OFFY'(1);
    assign x_inc     = {1'b0, x_reg} + (COORD_BITS+1)'(1);

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        in_r2_next    = in_r2_reg;
        finished_next = finished_reg;
        blank_next    = blank_reg;
        flag_next     = flag_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        rx2_next      = rx2_reg;
        ry2_next      = ry2_reg;
        dec_next      = dec_reg;
        s_next        = s_reg;
        dx_next       = dx_reg;
        mul_a         = '0;
        mul_b         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    blank_next = 1'b0;
                    if (restart)
                    begin
                        mode_next     = M_RESTART;
                        x_next        = '0;
                        y_next        = OFFY'(radius_y);
                        in_r2_next    = 1'b0;
                        finished_next = 1'b0;
                        state_next    = S_RX;
                    end
                    else if (finished_reg)
                    begin
                        blank_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (!in_r2_reg)
                    begin
                        mode_next  = M_REGION1;
                        x_next     = x_reg + COORD_BITS'(1);
                        state_next = S_RX;
                    end
                    else
                    begin
                        mode_next  = M_REGION2;
                        y_next     = y_reg - OFFY'(1);
                        state_next = S_RX;
                    end
                end
            end
            S_RX:
            begin
                mul_a      = MA'(radius_x);
                mul_b      = MB'(radius_x);
                state_next = S_RY;
            end
            S_RY:
            begin
                rx2_next = prod[MA-1:0];
                mul_a    = MA'(radius_y);
                mul_b    = MB'(radius_y);
                unique case (mode_reg)
                    M_RESTART: state_next = S_R2;
                    M_REGION1: state_next = S_A2;
                    M_REGION2: state_next = S_B2;
                    default:   state_next = S_IDLE;
                endcase
            end
            // restart: ry^2 + rx^2/4 - rx^2*ry
            S_R2:
            begin
                ry2_next   = prod[MA-1:0];
                dec_next   = DEC'(prod[MA-1:0]) + DEC'(rx2_reg >> 2);
                mul_a      = rx2_reg;
                mul_b      = MB'(radius_y);
                state_next = S_R3;
            end
            S_R3:
            begin
                dec_next   = dec_reg - DEC'(prod);
                state_next = S_OUT;
            end
            // region one: sign taken from the decision before the step
            S_A2:
            begin
                ry2_next  = prod[MA-1:0];
                mul_a     = prod[MA-1:0];
                mul_b     = MB'(x_reg);
                flag_next = !dec_neg;
                dec_next  = dec_reg + DEC'(prod[MA-1:0]);
                if (!dec_neg)
                begin
                    y_next = y_reg - OFFY'(1);
                end
                state_next = S_A3;
            end
            S_A3:
            begin
                dx_next    = step_term;
                dec_next   = dec_reg + DEC'(step_term);
                mul_a      = rx2_reg;
                mul_b      = MB'(y_reg);
                state_next = S_A4;
            end
            S_A4:
            begin
                if (flag_reg)
                begin
                    dec_next = dec_reg - DEC'(step_term);
                end
                if (dx_reg < step_term)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    in_r2_next = 1'b1;
                    state_next = S_C0;
                end
            end
            // region two
            S_B2:
            begin
                ry2_next  = prod[MA-1:0];
                flag_next = dec_neg || dec_zero;
                dec_next  = dec_reg + DEC'(rx2_reg);
                if (dec_neg || dec_zero)
                begin
                    x_next = x_reg + COORD_BITS'(1);
                end
                mul_a      = rx2_reg;
                mul_b      = MB'(y_reg);
                state_next = S_B3;
            end
            S_B3:
            begin
                dec_next   = dec_reg - DEC'(step_term);
                mul_a      = ry2_reg;
                mul_b      = MB'(x_reg);
                state_next = S_B4;
            end
            S_B4:
            begin
                if (flag_reg)
                begin
                    dec_next = dec_reg + DEC'(step_term);
                end
                state_next = S_OUT;
            end
            // region-two start, accumulated one partial product a cycle:
            // ry^2*x(x+1) + ry^2/4 + rx^2*(y-1)^2 - rx^2*ry^2
            S_C0:
            begin
                mul_a      = MA'(x_reg);
                mul_b      = MB'(x_inc);
                state_next = S_C1;
            end
            S_C1:
            begin
                s_next     = SW'(prod[2*COORD_BITS-1:0]);
                mul_a      = ry2_reg;
                mul_b      = MB'(prod[COORD_BITS-1:0]);
                state_next = S_C2;
            end
            S_C2:
            begin
                dec_next   = DEC'(prod) + DEC'(ry2_reg >> 2);
                mul_a      = ry2_reg;
                mul_b      = MB'(s_reg[2*COORD_BITS-1:COORD_BITS]);
                state_next = S_C3;
            end
            S_C3:
            begin
                dec_next   = dec_reg + DEC'({prod, {COORD_BITS{1'b0}}});
                mul_a      = MA'(ym1);
                mul_b      = MB'(ym1);
                state_next = S_C4;
            end
            S_C4:
            begin
                s_next     = prod[SW-1:0];
                mul_a      = rx2_reg;
                mul_b      = MB'(prod[COORD_BITS:0]);
                state_next = S_C5;
            end
            S_C5:
            begin
                dec_next   = dec_reg + DEC'(prod);
                mul_a      = rx2_reg;
                mul_b      = MB'(s_reg[SW-1:COORD_BITS+1]);
                state_next = S_C6;
            end
            S_C6:
            begin
                dec_next   = dec_reg + DEC'({prod, {(COORD_BITS+1){1'b0}}});
                mul_a      = rx2_reg;
                mul_b      = MB'(ry2_reg[COORD_BITS:0]);
                state_next = S_C7;
            end
            S_C7:
            begin
                dec_next   = dec_reg - DEC'(prod);
                mul_a      = rx2_reg;
                mul_b      = MB'(ry2_reg[MA-1:COORD_BITS+1]);
                state_next = S_C8;
            end
            S_C8:
            begin
                dec_next   = dec_reg - DEC'({prod, {(COORD_BITS+1){1'b0}}});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (!blank_reg && (y_reg == '0))
                    begin
                        finished_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_RESTART;
            in_r2_reg    <= 1'b0;
            finished_reg <= 1'b1;
            blank_reg    <= 1'b0;
            flag_reg     <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            in_r2_reg    <= in_r2_next;
            finished_reg <= finished_next;
            blank_reg    <= blank_next;
            flag_reg     <= flag_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        dec_reg <= dec_next;
        s_reg   <= s_next;
        dx_reg  <= dx_next;
    end

    assign ctl.idle  = (state_reg == S_IDLE);
    assign ctl.done  = (state_reg == S_OUT) && out_free;
    assign ctl.blank = blank_reg;
    assign offset_x  = x_reg;
    assign offset_y  = y_reg;

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && restart) |=>
            (!finished_reg && x_reg == '0 && y_reg == OFFY'($past(radius_y))))
        else $error("restart did not load the top point");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_free) |=>
            (state_reg == S_OUT && $stable(x_reg) && $stable(y_reg)))
        else $error("offsets moved while the result waited");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.done && !blank_reg && y_reg == '0) |=> finished_reg)
        else $error("last point did not end the ellipse");

    a_region_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A4) |=> ((state_reg == S_C0) == in_r2_reg))
        else $error("region flag out of step with the sequencer");

endmodule

`default_nettype wire

// ===== rtl/core/midpoint_ellipse_points.sv =====
// Midpoint ellipse point generator: top level with configuration registers,
// stream ports and the output register. Depends on mep_pkg, mep_core, mep_mul.
//
// Usage: centre and radii are written through cfg_we/cfg_addr/cfg_wdata
// (0 centre x, 1 centre y, 2 radius x, 3 radius y) while the block is idle.
// Each input transaction on s_axis (tdata bit 0: restart) yields exactly one
// result on m_axis: the four mirror coordinates in tdata, point valid in
// tuser and the last point (offset y zero) in tlast. Restart begins at
// (0, ry); a zero restart bit advances one point.
// From an input transaction to the result being loaded in the output
// register the sequencer passes S_RX, S_RY, S_R2 and S_R3 for a restart,
// and S_RX, S_RY and S_A2 to S_A4 or S_B2 to S_B4 for a step; the step that
// crosses into region two adds S_C0 to S_C8 and eight products for its start
// term; with no ellipse active it goes straight to S_OUT. The input side is
// ready again in the cycle after the result is loaded. Every product goes
// through the one registered multiplier, one product per cycle. Reset clears
// the registers, leaves no ellipse active and empties the output register.
// While the receiver stalls the result is held in the output register and
// the next item is accepted but waits for it to drain.
`default_nettype none

module midpoint_ellipse_points #(
    parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mep_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [COORD_BITS-1:0]                   cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,  // [0] restart
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // x_plus, x_minus, y_plus, y_minus from the lowest bit up, zero padded
    output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                    m_axis_tuser,  // point_valid
    output logic                                    m_axis_tlast   // last_point
);
    import mep_pkg::*;

    localparam int RAD  = COORD_BITS - 1;
    localparam int OUT  = COORD_BITS + 2;
    localparam int TD_W = ((4 * OUT + 7) / 8) * 8;

    logic [COORD_BITS-1:0]  center_x_reg;
    logic [COORD_BITS-1:0]  center_y_reg;
    logic [RAD-1:0]         radius_x_reg;
    logic [RAD-1:0]         radius_y_reg;

    logic                   m_valid_reg;
    logic [OUT-1:0]         x_plus_reg, x_plus_next;
    logic [OUT-1:0]         x_minus_reg, x_minus_next;
    logic [OUT-1:0]         y_plus_reg, y_plus_next;
    logic [OUT-1:0]         y_minus_reg, y_minus_next;
    logic                   user_reg, user_next;
    logic                   last_reg, last_next;

    seq_ctl_t               ctl;
    logic                   start;
    logic                   out_free;
    logic [COORD_BITS-1:0]  offset_x;
    logic [COORD_BITS:0]    offset_y;

    assign start    = s_axis_tvalid && ctl.idle;
    assign out_free = !m_valid_reg || m_axis_tready;

    mep_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .restart  (s_axis_tdata[0]),
        .radius_x (radius_x_reg),
        .radius_y (radius_y_reg),
        .out_free (out_free),
        .ctl      (ctl),
        .offset_x (offset_x),
        .offset_y (offset_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CENTER_X: center_x_reg <= cfg_wdata;
                CFG_CENTER_Y: center_y_reg <= cfg_wdata;
                CFG_RADIUS_X: radius_x_reg <= cfg_wdata[RAD-1:0];
                CFG_RADIUS_Y: radius_y_reg <= cfg_wdata[RAD-1:0];
                default:      center_x_reg <= center_x_reg;
            endcase
        end
    end

    always_comb
    begin
        if (ctl.blank)
        begin
            x_plus_next  = '0;
            x_minus_next = '0;
            y_plus_next  = '0;
            y_minus_next = '0;
            user_next    = 1'b0;
            last_next    = 1'b0;
        end
        else
        begin
            x_plus_next  = OUT'(center_x_reg) + OUT'(offset_x);
            x_minus_next = OUT'(center_x_reg) - OUT'(offset_x);
            y_plus_next  = OUT'(center_y_reg) + OUT'(offset_y);
            y_minus_next = OUT'(center_y_reg) - OUT'(offset_y);
            user_next    = 1'b1;
            last_next    = (offset_y == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.done)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            x_plus_reg  <= x_plus_next;
            x_minus_reg <= x_minus_next;
            y_plus_reg  <= y_plus_next;
            y_minus_reg <= y_minus_next;
            user_reg    <= user_next;
            last_reg    <= last_next;
        end
    end

    assign s_axis_tready = ctl.idle;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TD_W'({y_minus_reg, y_plus_reg, x_minus_reg, x_plus_reg});
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== tb/midpoint_ellipse_points_checker.sv =====
`timescale 1ns / 1ps
// Result checker for midpoint_ellipse_points: follows register writes and both
// stream channels, walks the ellipse itself and compares every result.
// Depends on mep_pkg for the register indexes.

module midpoint_ellipse_points_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mep_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [11:0]                  cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [0] restart
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // x_plus, x_minus, y_plus, y_minus from the lowest bit up
    input  logic [55:0]                  m_axis_tdata,
    input  logic                         m_axis_tuser,  // point_valid
    input  logic                         m_axis_tlast,  // last_point
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    import mep_pkg::*;

    typedef struct packed {
        logic [13:0] x_plus;
        logic [13:0] x_minus;
        logic [13:0] y_plus;
        logic [13:0] y_minus;
        logic        point_valid;
        logic        last_point;
    } ellipse_point_t;

    ellipse_point_t expected_points[$];

    // register copies
    logic [11:0] cx;
    logic [11:0] cy;
    logic [10:0] rx;
    logic [10:0] ry;

    // walk state
    logic [11:0] walk_x;
    logic [12:0] walk_y;
    logic [41:0] dec;
    logic [35:0] step_x;
    logic [35:0] step_y;
    logic        region_two;
    logic        walk_done;

    task automatic trace_next_point(input logic restart, output ellipse_point_t pt);
        logic [63:0] rx2;
        logic [63:0] ry2;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] xx;
        logic [63:0] ym1;
        rx2 = 64'(rx) * 64'(rx);
        ry2 = 64'(ry) * 64'(ry);
        pt  = '0;
        if (!restart && walk_done) begin
            pt = '0;
        end else begin
            if (restart) begin
                walk_x     = '0;
                walk_y     = 13'(ry);
                dec        = 42'(ry2 - rx2 * 64'(ry) + (rx2 >> 2));
                step_x     = '0;
                step_y     = '0;
                region_two = 1'b0;
                walk_done  = 1'b0;
            end else if (!region_two) begin
                walk_x = walk_x + 12'd1;
                dx = 64'(36'(64'd2 * ry2 * 64'(walk_x)));
                dy = 64'(36'(64'd2 * rx2 * 64'(walk_y)));
                if (!dec[41]) begin
                    walk_y = walk_y - 13'd1;
                    dy  = 64'(36'(64'd2 * rx2 * 64'(walk_y)));
                    dec = dec - 42'(dy);
                end
                dec    = dec + 42'(dx) + 42'(ry2);
                step_x = 36'(dx);
                step_y = 36'(dy);
                if (!(dx < dy)) begin
                    // region two start term from the current offsets
                    region_two = 1'b1;
                    xx  = 64'(walk_x);
                    ym1 = (walk_y != 13'd0) ? 64'(walk_y) - 64'd1 : 64'd1;
                    dec = 42'(ry2 * (xx * xx + xx) + (ry2 >> 2) + rx2 * ym1 * ym1
                              - rx2 * ry2);
                end
            end else begin
                walk_y = walk_y - 13'd1;
                dx = 64'(36'(64'd2 * ry2 * 64'(walk_x)));
                dy = 64'(36'(64'd2 * rx2 * 64'(walk_y)));
                if (dec[41] || dec == '0) begin
                    walk_x = walk_x + 12'd1;
                    dx  = 64'(36'(64'd2 * ry2 * 64'(walk_x)));
                    dec = dec + 42'(dx);
                end
                dec    = dec - 42'(dy) + 42'(rx2);
                step_x = 36'(dx);
                step_y = 36'(dy);
            end
            pt.x_plus      = 14'(cx) + 14'(walk_x);
            pt.x_minus     = 14'(cx) - 14'(walk_x);
            pt.y_plus      = 14'(cy) + 14'(walk_y);
            pt.y_minus     = 14'(cy) - 14'(walk_y);
            pt.point_valid = 1'b1;
            pt.last_point  = (walk_y == 13'd0);
            if (walk_y == 13'd0)
                walk_done = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ellipse_point_t want;
        ellipse_point_t got;
        if (!rst_n) begin
            expected_points.delete();
            cx = '0;
            cy = '0;
            rx = '0;
            ry = '0;
            walk_x = '0;
            walk_y = '0;
            dec = '0;
            step_x = '0;
            step_y = '0;
            region_two = 1'b0;
            walk_done = 1'b1;
            fail_count = 0;
            pending = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_CENTER_X: cx = cfg_wdata;
                    CFG_CENTER_Y: cy = cfg_wdata;
                    CFG_RADIUS_X: rx = cfg_wdata[10:0];
                    CFG_RADIUS_Y: ry = cfg_wdata[10:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.x_plus      = m_axis_tdata[13:0];
                got.x_minus     = m_axis_tdata[27:14];
                got.y_plus      = m_axis_tdata[41:28];
                got.y_minus     = m_axis_tdata[55:42];
                got.point_valid = m_axis_tuser;
                got.last_point  = m_axis_tlast;
                if (expected_points.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.x_plus !== want.x_plus) begin
                        $error("x_plus expected %0d got %0d",
                               $signed(want.x_plus), $signed(got.x_plus));
                        fail_count++;
                    end
                    if (got.x_minus !== want.x_minus) begin
                        $error("x_minus expected %0d got %0d",
                               $signed(want.x_minus), $signed(got.x_minus));
                        fail_count++;
                    end
                    if (got.y_plus !== want.y_plus) begin
                        $error("y_plus expected %0d got %0d",
                               $signed(want.y_plus), $signed(got.y_plus));
                        fail_count++;
                    end
                    if (got.y_minus !== want.y_minus) begin
                        $error("y_minus expected %0d got %0d",
                               $signed(want.y_minus), $signed(got.y_minus));
                        fail_count++;
                    end
                    if (got.point_valid !== want.point_valid) begin
                        $error("point_valid expected %0d got %0d",
                               want.point_valid, got.point_valid);
                        fail_count++;
                    end
                    if (got.last_point !== want.last_point) begin
                        $error("last_point expected %0d got %0d",
                               want.last_point, got.last_point);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                trace_next_point(s_axis_tdata[0], want);
                expected_points.push_back(want);
            end
            pending = expected_points.size();
        end
    end

endmodule

// ===== tb/midpoint_ellipse_points_tb.sv =====
`timescale 1ns / 1ps
// Top of the midpoint_ellipse_points testbench: clock, reset, register set-up,
// input stimulus, output back-pressure and the verdict.
// Depends on mep_pkg, the block and midpoint_ellipse_points_checker.

module midpoint_ellipse_points_tb;

    import mep_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int results_seen;

    int  n_items = 0;
    int  n_restarts = 0;
    int  n_settings = 0;
    int  stall_cycles = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic no_idle = 1'b0;
    int  cur_rx = 0;
    int  cur_ry = 0;

    midpoint_ellipse_points dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    midpoint_ellipse_points_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output back-pressure; a hold request stalls the receiver for a long stretch
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("midpoint_ellipse_points verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic restart);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
        if (restart)
            n_restarts++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input int cx, input int cy, input int rx, input int ry);
        drain();
        write_reg(CFG_CENTER_X, 12'(cx));
        write_reg(CFG_CENTER_Y, 12'(cy));
        write_reg(CFG_RADIUS_X, 12'(rx));
        write_reg(CFG_RADIUS_Y, 12'(ry));
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_rx = rx;
        cur_ry = ry;
        n_settings++;
    endtask

    // well-formed walks with random length, plus stray advances and early restarts
    task automatic run_walks(input int budget);
        int sent;
        int span;
        int n;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 5) begin
                send_item(1'b0);
                sent++;
            end else begin
                send_item(1'b1);
                sent++;
                span = cur_rx + cur_ry;
                if ($urandom_range(0, 99) < 80)
                    n = span + $urandom_range(0, 3);
                else
                    n = $urandom_range(0, span);
                for (int i = 0; i < n && sent < budget; i++) begin
                    send_item(1'b0);
                    sent++;
                end
            end
        end
    endtask

    function automatic int pick_centre();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 4095;
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_radius();
        if ($urandom_range(0, 9) == 0)
            return 0;
        return $urandom_range(1, 40);
    endfunction

    initial
    begin
        int phase;
        int goal;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no ellipse active after reset
        send_item(1'b0);
        send_item(1'b0);
        // all registers zero: restart point is the last point
        send_item(1'b1);
        send_item(1'b0);
        // zero horizontal radius at the top corner
        set_config(4095, 4095, 0, 3);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        // largest radii around the origin
        set_config(0, 0, 2047, 2047);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        // registers changed part way through a walk, then an early restart
        set_config(100, 200, 6, 4);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        set_config(1000, 200, 10, 4);
        repeat (8) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);

        goal  = n_items + RANDOM_ITEMS;
        phase = 0;
        while (n_items < goal) begin
            case (phase)
                0: set_config(4095, 4095, 2047, 2047);
                1: set_config(pick_centre(), pick_centre(), 2047, $urandom_range(1, 8));
                2: set_config(pick_centre(), pick_centre(), 3, 2047);
                default: set_config(pick_centre(), pick_centre(), pick_radius(), pick_radius());
            endcase
            if (phase == 3)
                hold_reqs++;
            no_idle = (phase == 5);
            if (phase < 3)
                run_walks(150);
            else
                run_walks($urandom_range(80, 160));
            phase++;
        end
        no_idle = 1'b0;

        drain();
        repeat (20) @(negedge clk);
        $display("Covered %0d input transactions (%0d restarts), %0d results, %0d settings",
                 n_items, n_restarts, results_seen, n_settings);
        $display("including blank points, extreme radii, a long output stall and idle-free run");
        if (fail_count == 0 && pending == 0)
            $display("midpoint_ellipse_points verification clean");
        else
            $display("midpoint_ellipse_points verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mep_pkg.sv
rtl/core/mep_mul.sv
rtl/core/mep_core.sv
rtl/core/midpoint_ellipse_points.sv
tb/midpoint_ellipse_points_checker.sv
tb/midpoint_ellipse_points_tb.sv
